// ===== rtl/core/pswpa_pkg.sv =====
package pswpa_pkg;

  localparam int WINDOW_LEN = 25;
  localparam int SAMPLE_W   = 16;
  localparam int TOTAL_W    = $clog2(WINDOW_LEN * 65535 + 1);
  localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 12;
  localparam int CLR_SCALE  = 100;

  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_CONTROL = 1'b1;

  localparam logic [15:0] GAIN_P_RST      = 16'd4096;
  localparam logic [15:0] GAIN_I_RST      = 16'd410;
  localparam logic [15:0] GAIN_D_RST      = 16'd0;
  localparam logic [15:0] DRIVE_FLOOR_RST = 16'd1280;
  localparam logic [15:0] DRIVE_CEIL_RST  = 16'd1720;
  localparam logic [15:0] ERR_LIMIT_RST   = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_DRIVE_FLOOR = 3'd3,
    REG_DRIVE_CEIL  = 3'd4,
    REG_ERR_LIMIT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] edge_time;
    logic        pin_high;
    logic [15:0] target;
    logic [15:0] measured;
  } req_t;

  typedef struct packed {
    logic [15:0] drive_value;
    logic [15:0] averaged_width;
    logic [15:0] last_interval;
    logic        integral_cleared;
  } rsp_t;

  typedef struct packed {
    logic signed [16:0] err;
    logic signed [31:0] integ;
    logic signed [17:0] deriv;
    logic               cleared;
  } ctrl_t;

  typedef struct packed {
    logic        is_ctrl;
    ctrl_t       ctrl;
    logic [15:0] avg;
    logic [15:0] interval;
  } front_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [15:0]        drive_floor;
    logic [15:0]        drive_ceiling;
  } pid_cfg_t;

endpackage

// ===== rtl/core/pid_servo_with_pulse_average_core.sv =====
// PID servo with pulse-width averaging.
// req channel (req_valid/req_ready/req): one item per transfer. req_type selects a
//   capture edge (edge_time, pin_high) or a control step (target, measured).
// rsp channel (rsp_valid/rsp_ready/rsp): exactly one result per request, in order,
//   carrying the drive value, window average, last interval and integral-clear flag.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes, always
//   ready; indexes above the register list are ignored. Write only while idle.
// Path: a request passes the input register, front stage, product stage and
//   output register before its result shows on rsp.
// Throughput: one request per cycle while rsp is not stalled; the gain products
//   are registered between the front stage and the sum/clamp stage.
// Stalls: while rsp_ready is low the pipeline fills its empty stages and keeps
//   accepting until four requests are held, then drops req_ready.
// Reset (rst, synchronous): pipeline empties, the averaging window, integral,
//   edge history and drive are cleared, registers return to their defaults.
//   Requests are accepted in the first cycle after reset.
module pid_servo_with_pulse_average_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  pswpa_pkg::req_t                      req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output pswpa_pkg::rsp_t                      rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pswpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                          cfg_data
);
  import pswpa_pkg::*;

  logic        s0_valid;
  req_t        s0;
  logic        s1_valid;
  front_t      s1;
  front_t      s1_next;
  logic        s2_valid;

  logic        rdy1;
  logic        rdy2;
  logic        rdy3;
  logic        move0;
  logic        move2;

  pid_cfg_t    cfg;
  logic [15:0] err_limit;

  logic [15:0] interval;
  logic [15:0] average;
  logic [15:0] after_interval;
  logic [15:0] after_average;
  ctrl_t       ctrl_res;
  rsp_t        pid_res;
  logic        is_ctrl;

  assign rdy3      = !rsp_valid || rsp_ready;
  assign rdy2      = !s2_valid || rdy3;
  assign rdy1      = !s1_valid || rdy2;
  assign req_ready = !s0_valid || rdy1;
  assign move0     = s0_valid && rdy1;
  assign move2     = s2_valid && rdy3;
  assign cfg_ready = 1'b1;
  assign is_ctrl   = (s0.req_type == REQ_CONTROL);

  pswpa_window u_window (
    .clk            (clk),
    .rst            (rst),
    .capture        (move0 && (s0.req_type == REQ_CAPTURE)),
    .edge_time      (s0.edge_time),
    .pin_high       (s0.pin_high),
    .interval       (interval),
    .average        (average),
    .after_interval (after_interval),
    .after_average  (after_average)
  );

  pswpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (move0 && is_ctrl),
    .target    (s0.target),
    .measured  (s0.measured),
    .interval  (interval),
    .average   (average),
    .err_limit (err_limit),
    .result    (ctrl_res)
  );

  always_comb begin
    s1_next.is_ctrl  = is_ctrl;
    s1_next.ctrl     = is_ctrl ? ctrl_res : '0;
    s1_next.avg      = is_ctrl ? average : after_average;
    s1_next.interval = is_ctrl ? interval : after_interval;
  end

  pswpa_pid u_pid (
    .clk    (clk),
    .rst    (rst),
    .load   (rdy2),
    .front  (s1),
    .cfg    (cfg),
    .emit   (move2),
    .result (pid_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        s0_valid <= req_valid;
      end
      if (rdy1) begin
        s1_valid <= s0_valid;
      end
      if (rdy2) begin
        s2_valid <= s1_valid;
      end
      if (rdy3) begin
        rsp_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      s0 <= req;
    end
    if (rdy1) begin
      s1 <= s1_next;
    end
    if (rdy3) begin
      rsp <= pid_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p        <= GAIN_P_RST;
      cfg.gain_i        <= GAIN_I_RST;
      cfg.gain_d        <= GAIN_D_RST;
      cfg.drive_floor   <= DRIVE_FLOOR_RST;
      cfg.drive_ceiling <= DRIVE_CEIL_RST;
      err_limit         <= ERR_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P:      cfg.gain_p        <= cfg_data;
        REG_GAIN_I:      cfg.gain_i        <= cfg_data;
        REG_GAIN_D:      cfg.gain_d        <= cfg_data;
        REG_DRIVE_FLOOR: cfg.drive_floor   <= cfg_data;
        REG_DRIVE_CEIL:  cfg.drive_ceiling <= cfg_data;
        REG_ERR_LIMIT:   err_limit         <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/pswpa_window.sv =====
module pswpa_window (
  input  logic        clk,
  input  logic        rst,
  input  logic        capture,
  input  logic [15:0] edge_time,
  input  logic        pin_high,
  output logic [15:0] interval,
  output logic [15:0] average,
  output logic [15:0] after_interval,
  output logic [15:0] after_average
);
  import pswpa_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_LEN - 1);
  localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W     = TOTAL_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

  logic [15:0]                 prev_edge;
  logic [15:0]                 store [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]       filled;
  logic [POS_W-1:0]            pos;
  logic [TOTAL_W-1:0]          total;
  logic [15:0]                 oldest;
  logic [TOTAL_W-1:0]          total_next;
  logic [TOTAL_W+RECIP_W-1:0]  quot_prod;
  logic [15:0]                 avg_next;

  // exact floor(total / WINDOW_LEN) over the whole total range
  assign after_interval = edge_time - prev_edge;
  assign oldest         = filled[pos] ? store[pos] : '0;
  assign total_next     = total - TOTAL_W'(oldest) + TOTAL_W'(after_interval);
  assign quot_prod      = (TOTAL_W+RECIP_W)'(total_next) * (TOTAL_W+RECIP_W)'(RECIP);
  assign avg_next       = quot_prod[RECIP_SHIFT +: 16];
  assign after_average  = pin_high ? avg_next : average;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_edge <= '0;
      interval  <= '0;
      filled    <= '0;
      pos       <= '0;
      total     <= '0;
      average   <= '0;
    end else if (capture) begin
      prev_edge <= edge_time;
      interval  <= after_interval;
      if (pin_high) begin
        filled[pos] <= 1'b1;
        pos         <= (pos == LAST_POS) ? '0 : pos + 1'b1;
        total       <= total_next;
        average     <= avg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture && pin_high) begin
      store[pos] <= after_interval;
    end
  end

endmodule

// ===== rtl/core/pswpa_ctrl.sv =====
module pswpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [15:0]         target,
  input  logic [15:0]         measured,
  input  logic [15:0]         interval,
  input  logic [15:0]         average,
  input  logic [15:0]         err_limit,
  output pswpa_pkg::ctrl_t    result
);
  import pswpa_pkg::*;

  localparam int SCALED_W = $clog2(CLR_SCALE * 65535 + 1);
  localparam logic signed [31:0] INTEG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INTEG_MIN = 32'sh8000_0000;

  logic signed [31:0]   integral;
  logic signed [16:0]   prev_err;
  logic signed [16:0]   err;
  logic [32:0]          integ_sum;
  logic signed [31:0]   integ_sat;
  logic [31:0]          scaled_target;
  logic [SCALED_W-1:0]  scaled_avg;
  logic                 ratio_clear;
  logic                 over_limit;
  logic                 clear;

  assign err       = $signed({1'b0, target}) - $signed({1'b0, measured});
  assign integ_sum = {integral[31], integral} + {{16{err[16]}}, err};

  always_comb begin
    if (integ_sum[32] != integ_sum[31]) begin
      integ_sat = integ_sum[32] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_sat = integ_sum[31:0];
    end
  end

  assign scaled_target = 32'(target) * 32'(interval);
  assign scaled_avg    = SCALED_W'(average) * SCALED_W'(CLR_SCALE);
  assign ratio_clear   = (interval == '0) ? (average != '0)
                                          : (32'(scaled_avg) >= scaled_target);
  assign over_limit    = err > $signed({1'b0, err_limit});
  assign clear         = ratio_clear || (err == '0) || over_limit;

  assign result.err     = err;
  assign result.integ   = clear ? '0 : integ_sat;
  assign result.deriv   = {err[16], err} - {prev_err[16], prev_err};
  assign result.cleared = clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
    end else if (step) begin
      integral <= result.integ;
      prev_err <= err;
    end
  end

endmodule

// ===== rtl/core/pswpa_pid.sv =====
module pswpa_pid (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  pswpa_pkg::front_t   front,
  input  pswpa_pkg::pid_cfg_t cfg,
  input  logic                emit,
  output pswpa_pkg::rsp_t     result
);
  import pswpa_pkg::*;

  localparam int SUM_W = 50;
  localparam int Q_W   = SUM_W - FRAC_BITS;
  localparam logic [SUM_W-1:0] ROUND_BIAS = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);

  logic               s2_ctrl;
  logic               s2_cleared;
  logic [15:0]        s2_avg;
  logic [15:0]        s2_interval;
  logic signed [32:0] prod_p;
  logic signed [47:0] prod_i;
  logic signed [33:0] prod_d;
  logic [15:0]        drive_reg;

  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_adj;
  logic signed [Q_W-1:0]   q;
  logic [15:0]             drive_new;

  always_ff @(posedge clk) begin
    if (load) begin
      s2_ctrl     <= front.is_ctrl;
      s2_cleared  <= front.ctrl.cleared;
      s2_avg      <= front.avg;
      s2_interval <= front.interval;
      prod_p      <= $signed(front.ctrl.err) * $signed(cfg.gain_p);
      prod_i      <= $signed(front.ctrl.integ) * $signed(cfg.gain_i);
      prod_d      <= $signed(front.ctrl.deriv) * $signed(cfg.gain_d);
    end
  end

  // divide by 2^FRAC_BITS, truncating toward zero
  assign sum     = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
  assign sum_adj = sum + (sum[SUM_W-1] ? ROUND_BIAS : '0);
  assign q       = sum_adj[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (q < $signed({{(Q_W-16){1'b0}}, cfg.drive_floor})) begin
      drive_new = cfg.drive_floor;
    end else if (q > $signed({{(Q_W-16){1'b0}}, cfg.drive_ceiling})) begin
      drive_new = cfg.drive_ceiling;
    end else begin
      drive_new = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_reg <= '0;
    end else if (emit && s2_ctrl) begin
      drive_reg <= drive_new;
    end
  end

  assign result.drive_value      = s2_ctrl ? drive_new : drive_reg;
  assign result.averaged_width   = s2_avg;
  assign result.last_interval    = s2_interval;
  assign result.integral_cleared = s2_ctrl & s2_cleared;

endmodule

// ===== rtl/core/pswpa_checker.sv =====
module pswpa_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input pswpa_pkg::rsp_t   rsp
);
  import pswpa_pkg::*;

  localparam logic [2:0] DEPTH = 3'd4;

  logic [2:0] inflight;
  logic       acc;
  logic       del;

  assign acc = req_valid && req_ready;
  assign del = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(acc) - 3'(del);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    del |-> inflight != '0)
    else $error("result transfer with no request outstanding");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (inflight == DEPTH) && !rsp_ready |-> !req_ready && (inflight <= DEPTH))
    else $error("request taken while pipeline full and stalled");

endmodule

bind pid_servo_with_pulse_average_core pswpa_checker u_pswpa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== sim/pid_servo_with_pulse_average_core_test.sv =====
`timescale 1ns / 100ps

import pswpa_pkg::*;

class servo_scoreboard;
  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;

  logic signed [15:0] kp, ki, kd;
  logic [15:0] drive_lo, drive_hi, err_limit;
  logic [15:0] last_edge, interval, avg, drive;
  logic [15:0] window [WINDOW_LEN];
  logic [TOTAL_W-1:0] window_sum;
  int unsigned wpos;
  logic signed [31:0] integ;
  logic signed [17:0] last_err;
  rsp_t pending_results [$];
  int n_capture, n_control, n_cleared, n_checked, n_bad;

  function new();
    kp = GAIN_P_RST;
    ki = GAIN_I_RST;
    kd = GAIN_D_RST;
    drive_lo = DRIVE_FLOOR_RST;
    drive_hi = DRIVE_CEIL_RST;
    err_limit = ERR_LIMIT_RST;
    last_edge = '0;
    interval = '0;
    avg = '0;
    drive = '0;
    window_sum = '0;
    wpos = 0;
    integ = '0;
    last_err = '0;
    foreach (window[k]) window[k] = '0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      REG_GAIN_P:      kp = data;
      REG_GAIN_I:      ki = data;
      REG_GAIN_D:      kd = data;
      REG_DRIVE_FLOOR: drive_lo = data;
      REG_DRIVE_CEIL:  drive_hi = data;
      REG_ERR_LIMIT:   err_limit = data;
      default: ;
    endcase
  endfunction

  function void capture_edge(logic [15:0] t, logic high);
    interval = t - last_edge;
    last_edge = t;
    if (high) begin
      window_sum = window_sum - window[wpos] + interval;
      window[wpos] = interval;
      wpos = (wpos + 1) % WINDOW_LEN;
      avg = 16'(window_sum / WINDOW_LEN);
    end
  endfunction

  function bit control_step(logic [15:0] tgt, logic [15:0] meas);
    longint err, acc, deriv, total, q;
    bit clr;
    err = longint'(tgt) - longint'(meas);
    acc = longint'(integ) + err;
    if (acc > ACC_MAX) acc = ACC_MAX;
    else if (acc < ACC_MIN) acc = ACC_MIN;
    if (interval == 16'd0) clr = (avg != 16'd0);
    else clr = longint'(avg) * CLR_SCALE >= longint'(tgt) * longint'(interval);
    if (err == 0 || err > longint'(err_limit)) clr = 1'b1;
    if (clr) acc = 0;
    integ = 32'(acc);
    deriv = err - longint'(last_err);
    last_err = 18'(err);
    total = err * longint'(kp) + acc * longint'(ki) + deriv * longint'(kd);
    q = total / (longint'(1) << FRAC_BITS);
    if (q < longint'(drive_lo)) q = drive_lo;
    else if (q > longint'(drive_hi)) q = drive_hi;
    drive = 16'(q);
    return clr;
  endfunction

  function void note_item(req_t item);
    rsp_t want;
    want.integral_cleared = 1'b0;
    if (item.req_type == REQ_CAPTURE) begin
      capture_edge(item.edge_time, item.pin_high);
      n_capture++;
    end else begin
      want.integral_cleared = control_step(item.target, item.measured);
      n_control++;
      if (want.integral_cleared) n_cleared++;
    end
    want.drive_value = drive;
    want.averaged_width = avg;
    want.last_interval = interval;
    pending_results.push_back(want);
  endfunction

  function void flag(string msg);
    n_bad++;
    if (n_bad <= 10) $display("%s", msg);
  endfunction

  function void check_result(rsp_t got);
    rsp_t want;
    n_checked++;
    if (pending_results.size() == 0) begin
      flag($sformatf("%0t: result with nothing outstanding: drive %0d avg %0d interval %0d clr %0d",
                     $time, got.drive_value, got.averaged_width, got.last_interval,
                     got.integral_cleared));
      return;
    end
    want = pending_results.pop_front();
    if (got.drive_value !== want.drive_value || got.averaged_width !== want.averaged_width ||
        got.last_interval !== want.last_interval ||
        got.integral_cleared !== want.integral_cleared)
      flag($sformatf({"%0t: result %0d mismatch (exp/got): drive %0d/%0d avg %0d/%0d ",
                      "interval %0d/%0d clr %0d/%0d"},
                     $time, n_checked, want.drive_value, got.drive_value,
                     want.averaged_width, got.averaged_width,
                     want.last_interval, got.last_interval,
                     want.integral_cleared, got.integral_cleared));
  endfunction
endclass

module pid_servo_with_pulse_average_core_test;
  import pswpa_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_SLACK = 8;
  localparam int PHASE_ITEMS = 450;
  localparam int WINDUP_STEPS = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  servo_scoreboard servo_check = new();

  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int n_cfg = 0;
  logic [15:0] stim_edge = '0;

  pid_servo_with_pulse_average_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        servo_check.write_register(cfg_index, cfg_data);
        n_cfg++;
      end
      if (req_valid && req_ready) servo_check.note_item(req);
      if (rsp_valid && rsp_ready) servo_check.check_result(rsp);
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_capture(input logic [15:0] t, input logic high);
    req_t item;
    item.req_type = REQ_CAPTURE;
    item.edge_time = t;
    item.pin_high = high;
    item.target = 16'($urandom_range(0, 65535));
    item.measured = 16'($urandom_range(0, 65535));
    stim_edge = t;
    send_item(item);
  endtask

  task automatic send_control(input logic [15:0] tgt, input logic [15:0] meas);
    req_t item;
    item.req_type = REQ_CONTROL;
    item.edge_time = 16'($urandom_range(0, 65535));
    item.pin_high = 1'($urandom_range(1));
    item.target = tgt;
    item.measured = meas;
    send_item(item);
  endtask

  task automatic send_random_item();
    int sel;
    int m;
    logic [15:0] t;
    logic [15:0] tgt;
    logic [15:0] meas;
    sel = $urandom_range(9);
    if ($urandom_range(1) == 0) begin
      if (sel == 0) t = 16'($urandom_range(0, 65535));
      else if (sel == 1) t = stim_edge;
      else if (sel < 5) t = stim_edge + 16'($urandom_range(1, 65535));
      else t = stim_edge + 16'($urandom_range(800, 2200));
      send_capture(t, 1'($urandom_range(1)));
    end else begin
      case (sel)
        0: tgt = 16'($urandom_range(0, 65535));
        1: tgt = 16'd0;
        2: tgt = 16'hFFFF;
        3, 4, 5: tgt = 16'($urandom_range(0, 300));
        default: tgt = 16'($urandom_range(0, 5000));
      endcase
      sel = $urandom_range(9);
      if (sel == 0) begin
        meas = 16'($urandom_range(0, 65535));
      end else if (sel == 1) begin
        meas = tgt;
      end else begin
        m = int'(tgt) - 1500 + int'($urandom_range(0, 3000));
        if (m < 0) m = 0;
        if (m > 65535) m = 65535;
        meas = 16'(m);
      end
      send_control(tgt, meas);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [15:0] kp, ki, kd, lo, hi, lim);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_DRIVE_FLOOR, lo);
    write_reg(REG_DRIVE_CEIL, hi);
    write_reg(REG_ERR_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (servo_check.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
  endtask

  task automatic run_directed();
    send_control(16'd1000, 16'd1000);     // zero error, nothing captured yet
    send_control(16'd1200, 16'd1000);     // zero interval and zero average: kept
    send_capture(16'd0, 1'b0);
    send_capture(16'd100, 1'b1);
    send_capture(16'd100, 1'b1);          // zero-length interval enters window
    send_control(16'd500, 16'd400);       // zero interval, average above zero
    send_capture(16'hFFFF, 1'b0);
    send_capture(16'd5, 1'b1);            // timer wrap
    send_control(16'd5000, 16'd4500);     // ratio test fails, integral kept
    send_control(16'd2000, 16'd1000);     // error equal to limit
    send_control(16'd2001, 16'd1000);     // error just above limit
    send_control(16'hFFFF, 16'd0);
    send_control(16'd0, 16'hFFFF);
    send_capture(16'd105, 1'b0);          // interval 100
    send_control(16'd4, 16'd2);           // ratio exactly equal
    send_control(16'd5, 16'd3);
    send_capture(16'hFFFF, 1'b1);
    send_capture(16'h0000, 1'b1);
    send_control(16'd1, 16'hFFFF);
    send_control(16'd300, 16'd100);
  endtask

  // Winds the integral up and back down: a tiny window average and a long
  // interval keep the ratio test from clearing it.
  task automatic run_windup();
    drain();
    write_reg(REG_ERR_LIMIT, 16'hFFFF);
    cfg_valid <= 1'b0;
    repeat (WINDOW_LEN) send_capture(stim_edge + 16'd1, 1'b1);
    send_capture(stim_edge + 16'd60000, 1'b0);
    send_control(16'hFFFF, 16'hFFFF);
    repeat (WINDUP_STEPS) send_control(16'hFFFF, 16'($urandom_range(0, 15)));
    send_control(16'd77, 16'd77);
    repeat (WINDUP_STEPS)
      send_control(16'($urandom_range(1, 15)), 16'hFFFF - 16'($urandom_range(0, 15)));
    send_control(16'd1, 16'hFFFF);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    run_directed();
    holds_asked <= holds_asked + 1;
    repeat (PHASE_ITEMS) send_random_item();
    run_windup();
    drain();

    write_reg(CFG_SPARE_LO, 16'h1234);
    program_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000);
    set_idling(73, 0);
    repeat (PHASE_ITEMS) send_random_item();
    drain();

    write_reg(CFG_SPARE_HI, 16'hFFFF);
    program_regs(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF);
    set_idling(0, 73);
    repeat (PHASE_ITEMS) send_random_item();
    drain();

    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    set_idling(31, 31);
    holds_asked <= holds_asked + 1;
    repeat (PHASE_ITEMS) send_random_item();
    drain();

    $display("Checked %0d results: %0d edge captures, %0d control steps, %0d integral clears.",
             servo_check.n_checked, servo_check.n_capture, servo_check.n_control,
             servo_check.n_cleared);
    $display("%0d register writes over four settings, integral wound both ways, %0d bad.",
             n_cfg, servo_check.n_bad);
    if (servo_check.n_bad == 0 && servo_check.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/pswpa_pkg.sv
rtl/core/pswpa_window.sv
rtl/core/pswpa_ctrl.sv
rtl/core/pswpa_pid.sv
rtl/core/pid_servo_with_pulse_average_core.sv
rtl/core/pswpa_checker.sv
sim/pid_servo_with_pulse_average_core_test.sv
